FILE: rtl/core/tpzs_pkg.sv
// Shared types, constants and the sine/cosine table for the torus point shader.
// No dependencies; tpzs_recip and the top level import this package.
`default_nettype none

package tpzs_pkg;

    // Screen store geometry
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_SIZE);

    // Angles and trig table
    localparam int ANGLE_STEPS = 1024;
    localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
    localparam int TRIG_W      = 16;

    // Field and register widths
    localparam int OP_W    = 2;
    localparam int PIX_W   = 13;
    localparam int GLYPH_W = 7;
    localparam int CFG_W_W = 8;
    localparam int CFG_H_W = 7;
    localparam int K1_W    = 16;
    localparam int INC_W   = 10;
    localparam int IDX_W   = CFG_W_W + CFG_H_W;

    // Fixed point datapath
    localparam int Q_W        = 18;
    localparam int Q_FRAC     = 14;
    localparam int COORD_FRAC = 12;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int ACC_W      = MUL_A_W + MUL_B_W;
    localparam int POS_W      = 16;
    localparam int LUM_W      = 20;
    localparam int PROJ_SHIFT = 36;
    localparam int R2         = 2;
    localparam int K2         = 5;
    localparam int H1_BASE    = R2 << COORD_FRAC;
    localparam int ZP_BIAS    = K2 << COORD_FRAC;
    localparam int ZP_W       = Q_W + 1;

    // Depth/shade store entry
    localparam int DEPTH_W   = 16;
    localparam int SHADE_W   = 4;
    localparam int RAM_W     = DEPTH_W + SHADE_W;
    localparam int LUM_SHIFT = Q_FRAC - 3;
    localparam int SHADE_MAX = 11;

    // Reciprocal depth divider
    localparam int RCP_NUM_W = 29;
    localparam int RCP_ONE   = 1 << 28;
    localparam int RCP_ZP_W  = Q_W;
    localparam int RCP_CNT_W = $clog2(RCP_NUM_W);

    // Opcodes
    localparam logic [OP_W-1:0] OP_PLOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_INC_A  = 3'd3;
    localparam logic [2:0] REG_INC_B  = 3'd4;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DEPTH_W-1:0]  quot;
    } rcp_stat_t;

    // Trig table, built at elaboration: {sin, cos} per entry, Q1.14
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [2*TRIG_W-1:0] trig_rom_t [ANGLE_STEPS];

    // Shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rm;
        q  = 0;
        rm = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rm = {rm[62:0], num[i]};
            if (rm >= den)
            begin
                rm   = rm - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [TRIG_W-1:0] sine_q14(input longint unsigned phase);
        logic              neg;
        longint unsigned   ph;
        longint unsigned   r;
        longint unsigned   r2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   qv;
        neg = 1'b0;
        ph  = phase;
        if (ph >= PI_Q30)
        begin
            ph  = ph - PI_Q30;
            neg = 1'b1;
        end
        if (ph > HALF_PI_Q30)
            ph = PI_Q30 - ph;
        r    = ph;
        r2   = (r * r) >> 30;
        term = r;
        sum  = longint'(r);
        for (int n = 1; n <= 8; n++)
        begin
            term = udiv((term * r2) >> 30, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        qv = (longint'(sum) + 32768) >> 16;
        return neg ? TRIG_W'(-qv) : TRIG_W'(qv);
    endfunction

    function automatic trig_rom_t build_trig_rom();
        trig_rom_t         t;
        longint unsigned   ph;
        longint unsigned   pc;
        for (int k = 0; k < ANGLE_STEPS; k++)
        begin
            ph = (longint'(k) * TWO_PI_Q30) >> ANGLE_W;
            pc = ph + HALF_PI_Q30;
            if (pc >= TWO_PI_Q30)
                pc = pc - TWO_PI_Q30;
            t[k] = {sine_q14(ph), sine_q14(pc)};
        end
        return t;
    endfunction

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

    // Shade code to ASCII: 0 blank, 1..12 the light ramp
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SHADE_W-1:0] s);
        logic [GLYPH_W-1:0] g;
        case (s)
            4'd1:    g = GLYPH_W'(".");
            4'd2:    g = GLYPH_W'(",");
            4'd3:    g = GLYPH_W'("-");
            4'd4:    g = GLYPH_W'("~");
            4'd5:    g = GLYPH_W'(":");
            4'd6:    g = GLYPH_W'(";");
            4'd7:    g = GLYPH_W'("=");
            4'd8:    g = GLYPH_W'("!");
            4'd9:    g = GLYPH_W'("*");
            4'd10:   g = GLYPH_W'("#");
            4'd11:   g = GLYPH_W'("$");
            4'd12:   g = GLYPH_W'("@");
            default: g = GLYPH_W'(" ");
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tpzs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module tpzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/tpzs_recip.sv
// Bit-serial reciprocal depth unit: round(2^28 / zp), saturated to 16 bits.
// Depends on tpzs_pkg.
`default_nettype none

module tpzs_recip
    import tpzs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [RCP_ZP_W-1:0] zp,
    output rcp_stat_t                stat
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [RCP_CNT_W-1:0]   cnt_reg;
    logic [RCP_NUM_W-1:0]   num_reg;
    logic [RCP_NUM_W-1:0]   quo_reg;
    logic [RCP_ZP_W-1:0]    rem_reg;
    logic [RCP_ZP_W-1:0]    den_reg;

    logic [RCP_ZP_W:0]      rem_sh;
    logic                   fits;

    assign rem_sh = {rem_reg, num_reg[RCP_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == RCP_CNT_W'(RCP_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= RCP_NUM_W'(RCP_ONE) + RCP_NUM_W'(zp >> 1);
            den_reg <= zp;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[RCP_NUM_W-2:0], fits};
            rem_reg <= fits ? RCP_ZP_W'(rem_sh - {1'b0, den_reg}) : RCP_ZP_W'(rem_sh);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = (|quo_reg[RCP_NUM_W-1:DEPTH_W]) ? '1 : quo_reg[DEPTH_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/torus_point_zbuffer_shader.sv
// Top level of the torus point z-buffer shader: stream ports, APB registers,
// sequencer with one shared multiply-accumulate. Depends on tpzs_pkg,
// tpzs_ram and tpzs_recip.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | tuser opcode, tdata tube/ring/pixel
//   m_*      | out | m_tvalid/m_tready  | tdata glyph (readout beats only)
//   apb      | in  | psel/penable       | 5 registers at 4*i, 32-bit data
//
// A plot beat's length is set by the 29-step bit-serial reciprocal and the
// single shared 34x18 multiplier that all rotation, lighting and projection
// products use; a plot beat ends early when the point falls off screen or
// is unlit.
// After reset the depth/shade RAM is cleared one entry a cycle and the frame
// trig is then loaded; s_tready stays low meanwhile.
// The glyph sits in an output register, so a new input beat is taken while
// a glyph still waits; only a second readout stalls on a full output.
`default_nettype none

module torus_point_zbuffer_shader
    import tpzs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [9:0] tube_angle, [19:10] ring_angle,
                                        // [32:20] pixel_index, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] glyph, [7] zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE,
        S_F_ADV, S_F_RA, S_F_RB, S_F_MSB, S_F_MCS, S_F_MCAB, S_F_MCCB,
        S_R_RD, S_R_OUT,
        S_P_RD_T, S_P_RD_P, S_P_T1A, S_P_T1B, S_P_T2A, S_P_T2B,
        S_P_XA, S_P_XB, S_P_YA, S_P_YB, S_P_U, S_P_ZA, S_P_ZB, S_P_ZP,
        S_P_M1, S_P_L1, S_P_M2, S_P_L2, S_P_L3, S_P_M3, S_P_M4, S_P_M5, S_P_L4,
        S_P_DIVW, S_P_PXA, S_P_PXB, S_P_PYA, S_P_PYB, S_P_IDX, S_P_RDM, S_P_WRM
    } state_t;

    typedef enum logic [1:0] {
        MAC_LOAD, MAC_ADD, MAC_SUB
    } mac_mode_t;

    localparam logic signed [ACC_W-1:0] MAC_HALF = ACC_W'(1) << (Q_FRAC - 1);

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [K1_W-1:0]    scale_reg;
    logic [INC_W-1:0]   inc_a_reg;
    logic [INC_W-1:0]   inc_b_reg;
    logic               cfg_we;

    // frame state and derived trig
    logic [ANGLE_W-1:0] angle_a_reg, angle_b_reg;
    q_t sa_reg, ca_reg, sb_reg, cb_reg;
    q_t msb_reg, mcs_reg, mcab_reg, mccb_reg;

    // item and working registers
    logic [ANGLE_W-1:0] theta_reg, phi_reg;
    logic [PIX_W-1:0]   pix_reg;
    q_t st_reg, ct_reg, sp_reg, cp_reg, h1_reg, h2_reg;
    q_t t1_reg, t2_reg, x_reg, y_reg, z_reg, tmp_reg, tmp2_reg;
    logic signed [LUM_W-1:0] lum_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DEPTH_W-1:0]      rev_reg;
    logic signed [POS_W-1:0] col_reg, row_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;

    // output register
    logic               m_tvalid_reg;
    logic [GLYPH_W-1:0] glyph_reg;

    // trig ROM
    logic [ANGLE_W-1:0]   rom_addr;
    logic [2*TRIG_W-1:0]  rom_q_reg;
    q_t rom_sin, rom_cos;

    // shared multiply-accumulate
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    mac_mode_t                 mac_mode;
    logic signed [ACC_W-1:0]   prod, mac_sum, rnd_full;
    q_t                        rnd_q;
    logic signed [POS_W-1:0]   proj_pos;

    // store
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [RAM_W-1:0]   ram_wdata, ram_q;

    // divider
    logic                    rcp_start;
    logic signed [ZP_W-1:0]  zp_s;
    rcp_stat_t               rcp_stat;

    logic                    in_beat;
    logic                    out_free;
    logic signed [POS_W-1:0] w_pos, h_pos;
    logic                    lum_pos, off_screen;
    logic signed [LUM_W-1:0] lum_sh;
    logic [SHADE_W-1:0]      shade_code;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_W'(80);
            height_reg <= CFG_H_W'(24);
            scale_reg  <= K1_W'(4224);
            inc_a_reg  <= INC_W'(2);
            inc_b_reg  <= INC_W'(2);
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_H_W-1:0];
                REG_SCALE:  scale_reg  <= pwdata[K1_W-1:0];
                REG_INC_A:  inc_a_reg  <= pwdata[INC_W-1:0];
                REG_INC_B:  inc_b_reg  <= pwdata[INC_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_SCALE:  prdata = 32'(scale_reg);
            REG_INC_A:  prdata = 32'(inc_a_reg);
            REG_INC_B:  prdata = 32'(inc_b_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- stream side ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, glyph_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- trig ROM, registered read ----------------
    always_ff @(posedge clk)
    begin
        rom_q_reg <= TRIG_ROM[rom_addr];
    end

    assign rom_sin = Q_W'($signed(rom_q_reg[2*TRIG_W-1:TRIG_W]));
    assign rom_cos = Q_W'($signed(rom_q_reg[TRIG_W-1:0]));

    // ---------------- depth/shade store ----------------
    tpzs_ram #(
        .WIDTH(RAM_W),
        .DEPTH(STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    // ---------------- reciprocal depth ----------------
    assign zp_s = ZP_W'(z_reg) + ZP_W'(ZP_BIAS);

    tpzs_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rcp_start),
        .zp    (zp_s[RCP_ZP_W-1:0]),
        .stat  (rcp_stat)
    );

    // ---------------- shared datapath ----------------
    assign prod     = mul_a * mul_b;
    assign rnd_full = (mac_sum + MAC_HALF) >>> Q_FRAC;
    assign rnd_q    = rnd_full[Q_W-1:0];
    assign proj_pos = POS_W'(mac_sum >>> PROJ_SHIFT);

    always_comb
    begin
        case (mac_mode)
            MAC_ADD: mac_sum = acc_reg + prod;
            MAC_SUB: mac_sum = acc_reg - prod;
            default: mac_sum = prod;
        endcase
    end

    assign w_pos   = $signed(POS_W'(width_reg));
    assign h_pos   = $signed(POS_W'(height_reg));
    assign lum_pos = !lum_reg[LUM_W-1] && (lum_reg != '0);
    assign off_screen = col_reg[POS_W-1] || (col_reg >= w_pos)
                     || row_reg[POS_W-1] || (row_reg >= h_pos) || !lum_pos;
    assign lum_sh  = lum_reg >>> LUM_SHIFT;
    assign shade_code = ((lum_sh > LUM_W'(SHADE_MAX)) ? SHADE_W'(SHADE_MAX)
                                                      : lum_sh[SHADE_W-1:0]) + 1'b1;

    // Operand select, address select and next state
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        mac_mode   = MAC_LOAD;
        rom_addr   = angle_a_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_reg[ADDR_W-1:0];
        ram_wdata  = '0;
        rcp_start  = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1))
                    state_next = S_F_RA;
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (s_tuser)
                        OP_PLOT:  state_next = S_P_RD_T;
                        OP_READ:  state_next = S_R_RD;
                        OP_FRAME: state_next = S_F_ADV;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            // frame advance and trig refresh
            S_F_ADV: state_next = S_F_RA;
            S_F_RA:
            begin
                rom_addr   = angle_a_reg;
                state_next = S_F_RB;
            end
            S_F_RB:
            begin
                rom_addr   = angle_b_reg;
                state_next = S_F_MSB;
            end
            S_F_MSB:
            begin
                mul_a = MUL_A_W'(sa_reg);
                mul_b = MUL_B_W'(rom_sin);
                state_next = S_F_MCS;
            end
            S_F_MCS:
            begin
                mul_a = MUL_A_W'(cb_reg);
                mul_b = MUL_B_W'(sa_reg);
                state_next = S_F_MCAB;
            end
            S_F_MCAB:
            begin
                mul_a = MUL_A_W'(ca_reg);
                mul_b = MUL_B_W'(sb_reg);
                state_next = S_F_MCCB;
            end
            S_F_MCCB:
            begin
                mul_a = MUL_A_W'(ca_reg);
                mul_b = MUL_B_W'(cb_reg);
                state_next = S_IDLE;
            end
            // readout
            S_R_RD:
            begin
                ram_addr   = pix_reg;
                state_next = S_R_OUT;
            end
            S_R_OUT:
            begin
                ram_addr = pix_reg;
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // plot: rotate
            S_P_RD_T:
            begin
                rom_addr   = theta_reg;
                state_next = S_P_RD_P;
            end
            S_P_RD_P:
            begin
                rom_addr   = phi_reg;
                state_next = S_P_T1A;
            end
            S_P_T1A:
            begin
                mul_a = MUL_A_W'(cb_reg);
                mul_b = MUL_B_W'(rom_cos);
                state_next = S_P_T1B;
            end
            S_P_T1B:
            begin
                mul_a = MUL_A_W'(msb_reg);
                mul_b = MUL_B_W'(sp_reg);
                mac_mode = MAC_ADD;
                state_next = S_P_T2A;
            end
            S_P_T2A:
            begin
                mul_a = MUL_A_W'(cp_reg);
                mul_b = MUL_B_W'(sb_reg);
                state_next = S_P_T2B;
            end
            S_P_T2B:
            begin
                mul_a = MUL_A_W'(mcs_reg);
                mul_b = MUL_B_W'(sp_reg);
                mac_mode = MAC_SUB;
                state_next = S_P_XA;
            end
            S_P_XA:
            begin
                mul_a = MUL_A_W'(h1_reg);
                mul_b = MUL_B_W'(t1_reg);
                state_next = S_P_XB;
            end
            S_P_XB:
            begin
                mul_a = MUL_A_W'(h2_reg);
                mul_b = MUL_B_W'(mcab_reg);
                mac_mode = MAC_SUB;
                state_next = S_P_YA;
            end
            S_P_YA:
            begin
                mul_a = MUL_A_W'(h1_reg);
                mul_b = MUL_B_W'(t2_reg);
                state_next = S_P_YB;
            end
            S_P_YB:
            begin
                mul_a = MUL_A_W'(h2_reg);
                mul_b = MUL_B_W'(mccb_reg);
                mac_mode = MAC_ADD;
                state_next = S_P_U;
            end
            S_P_U:
            begin
                mul_a = MUL_A_W'(ca_reg);
                mul_b = MUL_B_W'(h1_reg);
                state_next = S_P_ZA;
            end
            S_P_ZA:
            begin
                mul_a = MUL_A_W'(tmp_reg);
                mul_b = MUL_B_W'(sp_reg);
                state_next = S_P_ZB;
            end
            S_P_ZB:
            begin
                mul_a = MUL_A_W'(h2_reg);
                mul_b = MUL_B_W'(sa_reg);
                mac_mode = MAC_ADD;
                state_next = S_P_ZP;
            end
            S_P_ZP:
            begin
                if (!zp_s[ZP_W-1] && (zp_s != '0))
                begin
                    rcp_start  = 1'b1;
                    state_next = S_P_M1;
                end
                else
                    state_next = S_IDLE;
            end
            // plot: luminance, overlapped with the divider
            S_P_M1:
            begin
                mul_a = MUL_A_W'(cp_reg);
                mul_b = MUL_B_W'(ct_reg);
                state_next = S_P_L1;
            end
            S_P_L1:
            begin
                mul_a = MUL_A_W'(tmp_reg);
                mul_b = MUL_B_W'(sb_reg);
                state_next = S_P_M2;
            end
            S_P_M2:
            begin
                mul_a = MUL_A_W'(ca_reg);
                mul_b = MUL_B_W'(ct_reg);
                state_next = S_P_L2;
            end
            S_P_L2:
            begin
                mul_a = MUL_A_W'(tmp_reg);
                mul_b = MUL_B_W'(sp_reg);
                state_next = S_P_L3;
            end
            S_P_L3:
            begin
                mul_a = MUL_A_W'(sa_reg);
                mul_b = MUL_B_W'(st_reg);
                state_next = S_P_M3;
            end
            S_P_M3:
            begin
                mul_a = MUL_A_W'(ca_reg);
                mul_b = MUL_B_W'(st_reg);
                state_next = S_P_M4;
            end
            S_P_M4:
            begin
                mul_a = MUL_A_W'(ct_reg);
                mul_b = MUL_B_W'(sa_reg);
                state_next = S_P_M5;
            end
            S_P_M5:
            begin
                mul_a = MUL_A_W'(tmp2_reg);
                mul_b = MUL_B_W'(sp_reg);
                state_next = S_P_L4;
            end
            S_P_L4:
            begin
                mul_a = MUL_A_W'(cb_reg);
                mul_b = MUL_B_W'(tmp_reg);
                state_next = S_P_DIVW;
            end
            S_P_DIVW:
            begin
                if (rcp_stat.done)
                    state_next = S_P_PXA;
            end
            // plot: project
            S_P_PXA:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = $signed(MUL_B_W'(rev_reg));
                state_next = S_P_PXB;
            end
            S_P_PXB:
            begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = $signed(MUL_B_W'(scale_reg));
                state_next = S_P_PYA;
            end
            S_P_PYA:
            begin
                mul_a = -MUL_A_W'(y_reg);
                mul_b = $signed(MUL_B_W'(rev_reg));
                state_next = S_P_PYB;
            end
            S_P_PYB:
            begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = $signed(MUL_B_W'(scale_reg));
                state_next = S_P_IDX;
            end
            S_P_IDX:
            begin
                mul_a = MUL_A_W'(row_reg);
                mul_b = $signed(MUL_B_W'(width_reg));
                state_next = off_screen ? S_IDLE : S_P_RDM;
            end
            // plot: depth test, read then write back
            S_P_RDM:
            begin
                if (idx_reg[IDX_W-1:ADDR_W] != '0)
                    state_next = S_IDLE;
                else
                    state_next = S_P_WRM;
            end
            S_P_WRM:
            begin
                ram_wdata  = {rev_reg, shade_code};
                ram_we     = (rev_reg > ram_q[RAM_W-1:SHADE_W]);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            angle_a_reg  <= '0;
            angle_b_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            // angles wrap at a full turn through the natural width
            if (state_reg == S_F_ADV)
            begin
                angle_a_reg <= angle_a_reg + inc_a_reg;
                angle_b_reg <= angle_b_reg + inc_b_reg;
            end
            if (state_reg == S_R_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= mac_sum;
        if (in_beat)
        begin
            theta_reg <= s_tdata[9:0];
            phi_reg   <= s_tdata[19:10];
            pix_reg   <= s_tdata[32:20];
        end
        case (state_reg)
            S_F_RB:
            begin
                sa_reg <= rom_sin;
                ca_reg <= rom_cos;
            end
            S_F_MSB:
            begin
                sb_reg  <= rom_sin;
                cb_reg  <= rom_cos;
                msb_reg <= rnd_q;
            end
            S_F_MCS:  mcs_reg  <= rnd_q;
            S_F_MCAB: mcab_reg <= rnd_q;
            S_F_MCCB: mccb_reg <= rnd_q;
            S_R_OUT:
            begin
                if (out_free)
                    glyph_reg <= glyph_of(ram_q[SHADE_W-1:0]);
            end
            S_P_RD_P:
            begin
                st_reg <= rom_sin;
                ct_reg <= rom_cos;
                h1_reg <= Q_W'(Q_W'(H1_BASE) + ((rom_cos + 2) >>> 2));
                h2_reg <= Q_W'((rom_sin + 2) >>> 2);
            end
            S_P_T1A:
            begin
                sp_reg <= rom_sin;
                cp_reg <= rom_cos;
            end
            S_P_T1B:  t1_reg  <= rnd_q;
            S_P_T2B:  t2_reg  <= rnd_q;
            S_P_XB:   x_reg   <= rnd_q;
            S_P_YB:   y_reg   <= rnd_q;
            S_P_U:    tmp_reg <= rnd_q;
            S_P_ZB:   z_reg   <= rnd_q;
            S_P_M1:   tmp_reg <= rnd_q;
            S_P_L1:   lum_reg <= LUM_W'(rnd_q);
            S_P_M2:   tmp_reg <= rnd_q;
            S_P_L2:   lum_reg <= lum_reg - LUM_W'(rnd_q);
            S_P_L3:   lum_reg <= lum_reg - LUM_W'(rnd_q);
            S_P_M3:   tmp_reg <= rnd_q;
            S_P_M4:   tmp2_reg <= rnd_q;
            S_P_M5:   tmp_reg <= tmp_reg - rnd_q;
            S_P_L4:   lum_reg <= lum_reg + LUM_W'(rnd_q);
            S_P_DIVW: rev_reg <= rcp_stat.quot;
            S_P_PXB:  col_reg <= $signed(POS_W'(width_reg >> 1)) + proj_pos;
            S_P_PYB:  row_reg <= $signed(POS_W'(height_reg >> 1)) + proj_pos;
            S_P_IDX:  idx_reg <= mac_sum[IDX_W-1:0] + col_reg[IDX_W-1:0];
            default:  ;
        endcase
    end

`ifndef SYNTH
    // divider is never restarted while a division runs
    a_rcp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rcp_start |-> !rcp_stat.busy)
        else $error("reciprocal restarted while busy");

    // a started division is running on the next cycle
    a_rcp_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_ZP && rcp_start) |=> rcp_stat.busy)
        else $error("reciprocal did not start");

    // a waiting glyph holds the readout until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == S_R_OUT))
        else $error("readout left while output full");

    // frame angles move only on a frame beat
    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_F_ADV) |=> $stable(angle_a_reg) && $stable(angle_b_reg))
        else $error("frame angle changed outside frame advance");

    // store writes come only from clearing, readout or plot write-back
    a_store_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR || state_reg == S_R_OUT || state_reg == S_P_WRM))
        else $error("unexpected store write");
`endif

endmodule

`default_nettype wire
